>>> rtl/dtp_pkg.sv
// dtp_pkg: widths, constants and the arctangent table of the displacement to polar unit
// used by displacement_to_polar_unit; depends on nothing
package dtp_pkg;

  // coordinate and datapath widths
  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_ITER     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int GUARD_BITS   = 8;
  localparam int DIFF_W       = COORD_BITS + 1;
  // difference, guard bits, cordic gain times sqrt(2) and a spare sign bit
  localparam int CW           = DIFF_W + GUARD_BITS + 3;
  localparam int ZW           = 34;
  localparam int DIST_W       = 17;
  localparam int HEAD_W       = 16;
  localparam int GAIN_W       = 32;
  localparam int PROD_W       = CW - 1 + GAIN_W;
  localparam int DIST_SHIFT   = 32 + GUARD_BITS;
  localparam int HEAD_SHIFT   = 17;
  localparam int DFULL_W      = PROD_W + 1 - DIST_SHIFT;
  localparam int HFULL_W      = ZW + 1 - HEAD_SHIFT;

  localparam logic [GAIN_W-1:0]     INV_GAIN    = 32'd2608131496;
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [HEAD_W-1:0] PI_Q13   = 16'sd25736;
  localparam logic [DIST_W-1:0]     DIST_MAX    = 17'd131071;

  // round(atan(2^-i) * 2^30)
  localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

endpackage

>>> rtl/displacement_to_polar_unit.sv
// displacement_to_polar_unit: distance and atan2 heading between two points
// fully pipelined cordic vectoring; depends on dtp_pkg
//
// Takes a start and an end point (signed Q4.12) and returns the distance between
// them (unsigned Q5.12, saturated to 17 bits) and the heading from start to end
// (signed Q3.13 radians, clamped to -pi..pi). Coincident points give distance 0,
// heading 0 and same_point high. One item is accepted every clock cycle while the
// output is not stalled; each item passes through the pipeline stages in order: one
// quadrant pre-rotation stage, one stage per cordic step, one stage for the gain
// multiply and one for rounding and saturation. A stall at the output holds the whole
// pipeline, so the input stalls only while a finished result waits at the output.
module displacement_to_polar_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [dtp_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [dtp_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [dtp_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [dtp_pkg::COORD_BITS-1:0] end_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [dtp_pkg::DIST_W-1:0]     distance_o,
  output logic signed [dtp_pkg::HEAD_W-1:0]     heading_o,
  output logic                                  same_point_o
);

  localparam int N  = dtp_pkg::NUM_ITER;
  localparam int CW = dtp_pkg::CW;
  localparam int ZW = dtp_pkg::ZW;
  localparam int DW = dtp_pkg::DIFF_W;
  localparam int GB = dtp_pkg::GUARD_BITS;

  logic en;

  // cordic stage registers: index 0 is the pre-rotated vector
  logic signed [CW-1:0] x_q [N+1];
  logic signed [CW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic                 sp_q [N+1];
  logic [N:0]           v_q;

  // multiply stage
  logic [dtp_pkg::PROD_W-1:0]      prod_q;
  logic signed [dtp_pkg::HEAD_W-1:0] head_q;
  logic                            sp_m_q;
  logic                            v_m_q;

  // output stage
  logic                            v_o_q;
  logic [dtp_pkg::DIST_W-1:0]      dist_o_q;
  logic signed [dtp_pkg::HEAD_W-1:0] head_o_q;
  logic                            sp_o_q;

  assign en         = !(v_o_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- pre-rotation
  logic signed [DW-1:0] dx, dy, px, py;
  logic signed [ZW-1:0] pz;

  always_comb begin
    dx = {end_x_i[dtp_pkg::COORD_BITS-1], end_x_i}
       - {start_x_i[dtp_pkg::COORD_BITS-1], start_x_i};
    dy = {end_y_i[dtp_pkg::COORD_BITS-1], end_y_i}
       - {start_y_i[dtp_pkg::COORD_BITS-1], start_y_i};
    priority if (dx[DW-1] && !dy[DW-1]) begin
      px = dy;
      py = -dx;
      pz = dtp_pkg::HALF_PI_Q30;
    end else if (dx[DW-1]) begin
      px = -dy;
      py = dx;
      pz = -dtp_pkg::HALF_PI_Q30;
    end else begin
      px = dx;
      py = dy;
      pz = '0;
    end
  end

  // valid bits of the pre-rotation and cordic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]  <= {{(CW-DW-GB){px[DW-1]}}, px, {GB{1'b0}}};
      y_q[0]  <= {{(CW-DW-GB){py[DW-1]}}, py, {GB{1'b0}}};
      z_q[0]  <= pz;
      sp_q[0] <= (dx == '0) && (dy == '0);
    end
  end

  // ---------------------------------------------------------------- cordic steps
  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [CW-1:0] xs, ys;

    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sp_q[k+1] <= sp_q[k];
        if (!y_q[k][CW-1]) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + dtp_pkg::ATAN_Q30[k];
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - dtp_pkg::ATAN_Q30[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- gain multiply
  logic [CW-2:0]                     x_pos;
  logic signed [ZW:0]                z_rnd;
  logic signed [dtp_pkg::HFULL_W-1:0] h_full;
  logic signed [dtp_pkg::HEAD_W-1:0]  h_sat;

  always_comb begin
    x_pos  = x_q[N][CW-1] ? '0 : x_q[N][CW-2:0];
    z_rnd  = {z_q[N][ZW-1], z_q[N]} + (ZW+1)'(1 << 16);
    h_full = z_rnd[ZW:dtp_pkg::HEAD_SHIFT];
    priority if (h_full > dtp_pkg::HFULL_W'(dtp_pkg::PI_Q13)) begin
      h_sat = dtp_pkg::PI_Q13;
    end else if (h_full < -dtp_pkg::HFULL_W'(dtp_pkg::PI_Q13)) begin
      h_sat = -dtp_pkg::PI_Q13;
    end else begin
      h_sat = h_full[dtp_pkg::HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_m_q <= 1'b0;
    end else if (en) begin
      v_m_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= dtp_pkg::PROD_W'(x_pos) * dtp_pkg::PROD_W'(dtp_pkg::INV_GAIN);
      head_q <= h_sat;
      sp_m_q <= sp_q[N];
    end
  end

  // ---------------------------------------------------------------- round and saturate
  logic [dtp_pkg::PROD_W:0]         dsum;
  logic [dtp_pkg::DFULL_W-1:0]      dfull;
  logic [dtp_pkg::DIST_W-1:0]       dsat;

  always_comb begin
    dsum  = {1'b0, prod_q} + (dtp_pkg::PROD_W+1)'(64'd1 << (dtp_pkg::DIST_SHIFT - 1));
    dfull = dsum[dtp_pkg::PROD_W:dtp_pkg::DIST_SHIFT];
    if (dfull > dtp_pkg::DFULL_W'(dtp_pkg::DIST_MAX)) begin
      dsat = dtp_pkg::DIST_MAX;
    end else begin
      dsat = dfull[dtp_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o_q <= 1'b0;
    end else if (en) begin
      v_o_q <= v_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // coincident points: no direction, report zero
      dist_o_q <= sp_m_q ? '0 : dsat;
      head_o_q <= sp_m_q ? '0 : head_q;
      sp_o_q   <= sp_m_q;
    end
  end

  assign out_valid_o  = v_o_q;
  assign distance_o   = dist_o_q;
  assign heading_o    = head_o_q;
  assign same_point_o = sp_o_q;

  // ---------------------------------------------------------------- assertions
  a_same_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && same_point_o |-> distance_o == '0 && heading_o == '0)
    else $error("coincident points must give zero distance and heading");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_o <= dtp_pkg::PI_Q13 && heading_o >= -dtp_pkg::PI_Q13)
    else $error("heading outside -pi..pi");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(v_q) && $stable(v_m_q))
    else $error("pipeline moved while the output was stalled");

endmodule
